FILE: rtl/core/sha_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
        logic        length_overflow;
    } t_out_item;

    // Work unit handed from the front end to the compression engine.
    typedef struct packed {
        logic [511:0] block;      // 64 bytes, byte 0 in the top bits
        logic         emit;       // emit the digest after this block
        logic         overflow;   // length overflow flag for the digest
    } t_job;

    localparam logic [60:0] LEN_MAX = {61{1'b1}};
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS = 6'd56;

    localparam logic [255:0] INIT_H = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        begin
            case (t)
                6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

FILE: rtl/core/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: byte front end, job slot and round engine.
//
//   channel  | direction | handshake        | payload
//   ---------+-----------+------------------+-------------------------------
//   input    | in        | i_push / o_full  | i_item  (byte, present, end)
//   result   | out       | o_empty / i_pop  | o_item  (word, index, last, ovf)
//
// A full block or a padding block passes through the round engine as one
// load, 64 rounds and one feed-forward add; the single round unit sets the
// block rate. The front end keeps accepting bytes while the engine works
// and stalls (o_full) only while a block waits for it.
// The synchronous reset i_rst_n restores the initial hash value.
// The eight digest words leave one per transfer; the engine holds them
// until each is popped.
module sha256_stream_hasher (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sha_pkg::t_in_item  i_item,
    output logic               o_full,
    output logic               o_empty,
    output sha_pkg::t_out_item o_item,
    input  logic               i_pop
);

    logic          job_valid;
    logic          job_ready;
    sha_pkg::t_job job;

    sha_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_item     (i_item),
        .o_full     (o_full),
        .o_job_valid(job_valid),
        .o_job      (job),
        .i_job_ready(job_ready)
    );

    sha_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(job_valid),
        .i_job      (job),
        .o_job_ready(job_ready),
        .o_empty    (o_empty),
        .o_item     (o_item),
        .i_pop      (i_pop)
    );

endmodule

FILE: rtl/core/sha_front.sv
// Front end: collects message bytes into blocks and builds the padding blocks.
module sha_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sha_pkg::t_in_item i_item,
    output logic             o_full,
    output logic             o_job_valid,
    output sha_pkg::t_job    o_job,
    input  logic             i_job_ready
);

    logic [511:0] r_buf, n_buf;
    logic [5:0]   r_fill, n_fill;
    logic [60:0]  r_len, n_len;
    logic         r_ovf, n_ovf;
    logic         r_pend2, n_pend2;   // second padding block still to issue
    logic         r_lead80, n_lead80; // second padding block starts with 0x80
    logic         r_job_valid, n_job_valid;
    sha_pkg::t_job r_job, n_job;

    logic         byte_in;
    logic [511:0] pad_blk;
    logic [63:0]  bits;

    // One job slot; the front stalls while it is occupied or a second pad waits.
    assign o_full = r_job_valid || r_pend2;
    assign o_job_valid = r_job_valid;
    assign o_job = r_job;
    assign byte_in = i_push && !o_full && i_item.byte_present;

    always_comb begin
        n_buf = r_buf;
        n_fill = r_fill;
        n_len = r_len;
        n_ovf = r_ovf;
        n_pend2 = r_pend2;
        n_lead80 = r_lead80;
        n_job_valid = r_job_valid && !i_job_ready;
        n_job = r_job;
        pad_blk = '0;
        bits = '0;
        if (r_pend2 && !n_job_valid) begin
            // Second padding block: zeros and the bit length. After an end on a
            // full block it also carries the 0x80 marker in its first byte.
            n_job.block = {(r_lead80 ? sha_pkg::PAD_BYTE : 8'h00), 440'b0, r_len, 3'b000};
            n_job.emit = 1'b1;
            n_job.overflow = r_ovf;
            n_job_valid = 1'b1;
            n_pend2 = 1'b0;
            n_lead80 = 1'b0;
            n_len = '0;
            n_ovf = 1'b0;
        end else if (i_push && !o_full) begin
            if (byte_in) begin
                if (r_len == sha_pkg::LEN_MAX) begin
                    n_ovf = 1'b1;
                end else begin
                    n_len = r_len + 61'd1;
                end
                n_buf[511 - {r_fill, 3'b000} -: 8] = i_item.data_byte;
                n_fill = r_fill + 6'd1;
            end
            if (byte_in && r_fill == 6'd63) begin
                n_job.block = n_buf;
                n_job.emit = 1'b0;
                n_job.overflow = 1'b0;
                n_job_valid = 1'b1;
                if (i_item.end_of_message) begin
                    // Full block plus a padding-only block afterwards.
                    n_buf = '0;
                    n_buf[511 -: 8] = sha_pkg::PAD_BYTE;
                    n_fill = '0;
                    n_pend2 = 1'b1;
                    n_lead80 = 1'b1;
                end
            end else if (i_item.end_of_message) begin
                bits = {n_len, 3'b000};
                for (int i = 0; i < 64; i++) begin
                    if (i < n_fill) pad_blk[511 - 8 * i -: 8] = n_buf[511 - 8 * i -: 8];
                end
                pad_blk[511 - {n_fill, 3'b000} -: 8] = sha_pkg::PAD_BYTE;
                n_job.overflow = n_ovf;
                n_job_valid = 1'b1;
                if (n_fill < sha_pkg::LEN_POS) begin
                    pad_blk[63:0] = bits;
                    n_job.emit = 1'b1;
                    n_len = '0;
                    n_ovf = 1'b0;
                end else begin
                    n_job.emit = 1'b0;
                    n_pend2 = 1'b1;
                end
                n_fill = '0;
                n_job.block = pad_blk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        r_job <= n_job;
        if (!i_rst_n) begin
            r_fill <= '0;
            r_len <= '0;
            r_ovf <= 1'b0;
            r_pend2 <= 1'b0;
            r_lead80 <= 1'b0;
            r_job_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_len <= n_len;
            r_ovf <= n_ovf;
            r_pend2 <= n_pend2;
            r_lead80 <= n_lead80;
            r_job_valid <= n_job_valid;
        end
    end

endmodule

FILE: rtl/core/sha_core.sv
// Compression engine: 64 rounds, one per cycle, with digest word output.
module sha_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  sha_pkg::t_job     i_job,
    output logic              o_job_ready,
    output logic              o_empty,
    output sha_pkg::t_out_item o_item,
    input  logic              i_pop
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_ADD = 2'd2;
    localparam logic [1:0] ST_OUT = 2'd3;

    logic [1:0]   r_state;
    logic [5:0]   r_t;
    logic [2:0]   r_widx;
    logic [511:0] r_w;
    logic [255:0] r_h;
    logic [255:0] r_v;
    logic         r_emit, r_ovf;

    logic [31:0] a, b, c, d, e, f, g, h, w, s0, s1, wn, t1, t2;

    assign o_job_ready = (r_state == ST_IDLE);
    assign o_empty = (r_state != ST_OUT);
    assign o_item.digest_word = r_h[255 - {r_widx, 5'b0} -: 32];
    assign o_item.word_index = r_widx;
    assign o_item.last_word = (r_widx == 3'd7);
    assign o_item.length_overflow = r_ovf;

    always_comb begin
        {a, b, c, d, e, f, g, h} = r_v;
        w = r_w[511:480];
        s0 = sha_pkg::ror(r_w[479:448], 7) ^ sha_pkg::ror(r_w[479:448], 18)
           ^ (r_w[479:448] >> 3);
        s1 = sha_pkg::ror(r_w[63:32], 17) ^ sha_pkg::ror(r_w[63:32], 19)
           ^ (r_w[63:32] >> 10);
        wn = r_w[511:480] + s0 + r_w[223:192] + s1;
        t1 = h + (sha_pkg::ror(e, 6) ^ sha_pkg::ror(e, 11) ^ sha_pkg::ror(e, 25))
           + ((e & f) ^ (~e & g)) + sha_pkg::round_k(r_t) + w;
        t2 = (sha_pkg::ror(a, 2) ^ sha_pkg::ror(a, 13) ^ sha_pkg::ror(a, 22))
           + ((a & b) ^ (a & c) ^ (b & c));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_h <= sha_pkg::INIT_H;
            r_t <= '0;
            r_widx <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_w <= i_job.block;
                        r_v <= r_h;
                        r_emit <= i_job.emit;
                        r_ovf <= i_job.overflow;
                        r_t <= '0;
                        r_state <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    // The window shifts by one word; the new word enters at the end.
                    r_w <= {r_w[479:0], wn};
                    r_v <= {t1 + t2, a, b, c, d + t1, e, f, g};
                    r_t <= r_t + 6'd1;
                    if (r_t == 6'd63) r_state <= ST_ADD;
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[32 * i +: 32] <= r_h[32 * i +: 32] + r_v[32 * i +: 32];
                    end
                    r_widx <= '0;
                    r_state <= r_emit ? ST_OUT : ST_IDLE;
                end
                ST_OUT: begin
                    if (i_pop) begin
                        r_widx <= r_widx + 3'd1;
                        if (r_widx == 3'd7) begin
                            r_h <= sha_pkg::INIT_H;
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: tb/sv/sha256_digest_checker.sv
// Watches both channels of the SHA-256 stream hasher, predicts digests and compares them.
module sha256_digest_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  sha_pkg::t_in_item  i_item,
    input  logic               i_empty,
    input  logic               i_pop,
    input  sha_pkg::t_out_item i_result,
    output int                 o_fail_count,
    output int                 o_pending
);

    logic [31:0]        hash_state [8];
    logic [511:0]       block_acc;
    logic [6:0]         fill_cnt;
    logic [60:0]        byte_cnt;
    logic               len_ovf;
    sha_pkg::t_out_item digest_q [$];

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] kconst(input int t);
        logic [31:0] tab [64];
        tab = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
            32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
            32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
            32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
            32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return tab[t];
    endfunction

    task automatic absorb_block(input logic [511:0] blk);
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int t = 0; t < 16; t++) w[t] = blk[511 - 32 * t -: 32];
        for (int t = 16; t < 64; t++) begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(t) + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int i = 7; i > 0; i--) v[i] = v[i-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++) hash_state[i] = sha_pkg::INIT_H[255 - 32 * i -: 32];
        fill_cnt = '0;
        byte_cnt = '0;
        len_ovf  = 1'b0;
    endtask

    task automatic take_item(input sha_pkg::t_in_item it);
        logic [1023:0]      tail;
        logic [63:0]        bits;
        int                 total;
        sha_pkg::t_out_item r;
        if (it.byte_present) begin
            if (byte_cnt == sha_pkg::LEN_MAX) len_ovf = 1'b1;
            else byte_cnt = byte_cnt + 1'b1;
            block_acc[511 - 8 * fill_cnt -: 8] = it.data_byte;
            fill_cnt = fill_cnt + 1'b1;
            if (fill_cnt == 7'd64) begin
                absorb_block(block_acc);
                fill_cnt = '0;
            end
        end
        if (!it.end_of_message) return;
        tail = '0;
        for (int i = 0; i < fill_cnt; i++) tail[1023 - 8 * i -: 8] = block_acc[511 - 8 * i -: 8];
        tail[1023 - 8 * fill_cnt -: 8] = sha_pkg::PAD_BYTE;
        total = (fill_cnt < sha_pkg::LEN_POS) ? 64 : 128;
        bits = {byte_cnt, 3'b000};
        tail[1023 - 8 * (total - 8) -: 64] = bits;
        absorb_block(tail[1023:512]);
        if (total == 128) absorb_block(tail[511:0]);
        for (int i = 0; i < 8; i++) begin
            r.digest_word     = hash_state[i];
            r.word_index      = 3'(i);
            r.last_word       = (i == 7);
            r.length_overflow = len_ovf;
            digest_q = {digest_q, r};
        end
        restart_hash();
    endtask

    assign o_pending = digest_q.size();

    always @(posedge i_clk) begin
        sha_pkg::t_out_item want;
        if (!i_rst_n) begin
            restart_hash();
            digest_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_push && !i_full) take_item(i_item);
            if (i_pop && !i_empty) begin
                if (digest_q.size() == 0) begin
                    $error("unexpected digest word %h", i_result.digest_word);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = digest_q.pop_front();
                    if (want !== i_result) begin
                        if (want.digest_word !== i_result.digest_word)
                            $error("digest_word expected %h actual %h",
                                   want.digest_word, i_result.digest_word);
                        if (want.word_index !== i_result.word_index)
                            $error("word_index expected %0d actual %0d",
                                   want.word_index, i_result.word_index);
                        if (want.last_word !== i_result.last_word)
                            $error("last_word expected %b actual %b",
                                   want.last_word, i_result.last_word);
                        if (want.length_overflow !== i_result.length_overflow)
                            $error("length_overflow expected %b actual %b",
                                   want.length_overflow, i_result.length_overflow);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/sv/sha256_stream_hasher_tb.sv
// Testbench top for the SHA-256 stream hasher: stimulus, back pressure and verdict.
module sha256_stream_hasher_tb;

    // No transfer for this many cycles means the block is stuck. The limit
    // leaves a wide margin over a two-block padding pass.
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 280;
    localparam int DRAIN_CYCLES = 200;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_push = 1'b0;
    sha_pkg::t_in_item  i_item = '0;
    logic               o_full;
    logic               o_empty;
    sha_pkg::t_out_item o_item;
    logic               i_pop = 1'b0;

    int  fail_count;
    int  pending;
    int  item_count = 0;
    bit  quiet = 1'b0;
    int  idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    sha256_stream_hasher i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_item  (i_item),
        .o_full  (o_full),
        .o_empty (o_empty),
        .o_item  (o_item),
        .i_pop   (i_pop)
    );

    sha256_digest_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .i_full       (o_full),
        .i_item       (i_item),
        .i_empty      (o_empty),
        .i_pop        (i_pop),
        .i_result     (o_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offers one item starting at the next falling edge and returns once the
    // transfer has happened. Push stays high into the next call, so a
    // back-to-back item never sees push dropped and raised in one step.
    task automatic send_item(input logic [7:0] b, input logic present, input logic last);
        int gap;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
            i_push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_push <= 1'b1;
        i_item <= '{data_byte: b, byte_present: present, end_of_message: last};
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        item_count++;
    endtask

    // One message of n random bytes. Now and then an item with neither byte
    // nor end is slipped in; the block must ignore it. The final byte rides on
    // the end item half of the time, otherwise a separate empty end follows.
    task automatic send_message(input int n);
        bit joined;
        joined = (n > 0) && $urandom_range(0, 1);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                send_item(8'($urandom), 1'b0, 1'b0);
            end
            send_item(8'($urandom), 1'b1, joined && (i == n - 1));
        end
        if (!joined) send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // The result side stalls in bursts of random length until the quiet phase.
    initial begin
        int burst;
        burst = 0;
        forever begin
            @(negedge i_clk);
            if (quiet) begin
                i_pop <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                i_pop <= 1'b0;
            end else if ($urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 8) - 1;
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    // Any transfer on either channel resets the stall counter.
    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        int len;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: the empty message, a lone all-ones byte, an ignored
        // item, the classic three-byte message with a separate end, a zero byte and another empty message.
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item("a", 1'b1, 1'b0);
        send_item("b", 1'b1, 1'b0);
        send_item("c", 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        item_count = 0;

        // Random messages. Lengths cluster around the padding boundaries,
        // where one or two final blocks are needed or a block just fills.
        // The last message is cut short so the item total stays near the goal.
        while (item_count < RANDOM_ITEMS) begin
            if (item_count > RANDOM_ITEMS * 4 / 5) quiet = 1'b1;
            case ($urandom_range(0, 4))
                0: len = $urandom_range(0, 3);
                1: len = $urandom_range(54, 57);
                2: len = $urandom_range(62, 65);
                3: len = $urandom_range(118, 130);
                default: len = $urandom_range(0, 70);
            endcase
            if (len > RANDOM_ITEMS - item_count) len = RANDOM_ITEMS - item_count;
            send_message(len);
        end
        quiet = 1'b1;
        @(negedge i_clk);
        i_push <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
